### hdl/folrc_pkg.sv
// Package for the flash-or-latch relay controller.
// Holds the timer width, register defaults, register indexes and the mode encoding.
// No dependencies.
package folrc_pkg;

    localparam int TIMER_BITS   = 24;
    localparam int REG_BITS     = 24;
    localparam int CFG_IDX_BITS = 3;
    localparam int MODE_BITS    = 3;

    localparam logic [REG_BITS-1:0] DEBOUNCE_RST = REG_BITS'(10 * 24000);
    localparam logic [REG_BITS-1:0] MIN_ON_RST   = REG_BITS'(200 * 24000);
    localparam logic [REG_BITS-1:0] MIN_OFF_RST  = REG_BITS'(200 * 24000);
    localparam logic [REG_BITS-1:0] LATCH_RST    = REG_BITS'(350 * 24000);

    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_ON   = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_OFF  = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_LATCH    = CFG_IDX_BITS'(3);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_IDLE       = 3'd0,
        MODE_PRESS      = 3'd1,
        MODE_FLASH      = 3'd2,
        MODE_HOLD       = 3'd3,
        MODE_OFF_WAIT   = 3'd4,
        MODE_LATCHED    = 3'd5,
        MODE_CDEBOUNCE  = 3'd6,
        MODE_CANCELLING = 3'd7
    } t_mode;

    typedef struct packed {
        logic                 relay_on;
        logic [MODE_BITS-1:0] mode;
    } t_result;

endpackage

### hdl/folrc_intf.sv
// Handshake channels of the flash-or-latch relay controller.
// Depends on folrc_pkg for the mode field width.
interface folrc_in_if;
    logic valid;
    logic ready;
    logic switch_closed;

    modport source (output valid, output switch_closed, input ready);
    modport sink   (input valid, input switch_closed, output ready);
endinterface

interface folrc_out_if;
    logic                               valid;
    logic                               ready;
    logic                               relay_on;
    logic [folrc_pkg::MODE_BITS-1:0]    mode;

    modport source (output valid, output relay_on, output mode, input ready);
    modport sink   (input valid, input relay_on, input mode, output ready);
endinterface

### hdl/flash_or_latch_relay_controller.sv
// Top level of the flash-or-latch relay controller: state machine, two one-shot
// timers, configuration registers and a two-entry result buffer.
// Depends on folrc_pkg and the channel interfaces in folrc_intf.sv.
//
//   channel   direction  beat contents              accepted when
//   i_sw      in         switch_closed              valid && ready
//   o_res     out        relay_on, mode             valid && ready
//   i_cfg_*   in         register index, data       i_cfg_we
//
// Each switch beat updates the state and timer registers at the accepting edge,
// which also registers its result into the o_res entry, or the skid entry if held.
// A new beat is taken every cycle while ready is high; a two-entry result buffer
// lets input go on while one result waits; ready drops only when both are full.
// Reset restores the register defaults, the idle mode and cancelled timers.
module flash_or_latch_relay_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    folrc_in_if.sink                            i_sw,
    folrc_out_if.source                         o_res,
    input  logic                                i_cfg_we,
    input  logic [folrc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [folrc_pkg::REG_BITS-1:0]      i_cfg_data
);
    import folrc_pkg::*;

    logic [REG_BITS-1:0]   r_debounce, r_min_on, r_min_off, r_latch;

    t_mode                 r_mode, n_mode;
    logic                  r_relay, n_relay;
    logic [TIMER_BITS-1:0] r_press_cnt, r_flash_cnt;
    logic                  r_press_armed, r_flash_armed;

    logic                  press_exp, flash_exp;
    logic                  press_load, flash_load;
    logic                  press_cancel, flash_cancel;
    logic [REG_BITS-1:0]   press_val, flash_val;

    logic                  in_accept, out_pop;
    t_result               n_result;
    t_result               r_out, r_skid;
    logic                  r_out_valid, r_skid_valid;

    assign i_sw.ready = !r_skid_valid;
    assign in_accept  = i_sw.valid && !r_skid_valid;
    assign out_pop    = r_out_valid && o_res.ready;

    // Configuration registers; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_min_on   <= MIN_ON_RST;
            r_min_off  <= MIN_OFF_RST;
            r_latch    <= LATCH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                CFG_MIN_ON:   r_min_on   <= i_cfg_data;
                CFG_MIN_OFF:  r_min_off  <= i_cfg_data;
                CFG_LATCH:    r_latch    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Expiry is judged on the counts held before this beat.
    assign press_exp = r_press_armed && (r_press_cnt == '0);
    assign flash_exp = r_flash_armed && (r_flash_cnt == '0);

    always_comb begin
        n_mode       = r_mode;
        n_relay      = r_relay;
        press_load   = 1'b0;
        flash_load   = 1'b0;
        press_cancel = 1'b0;
        flash_cancel = 1'b0;
        press_val    = r_debounce;
        flash_val    = r_min_on;
        unique case (r_mode)
            MODE_IDLE: begin
                n_relay      = 1'b0;
                press_cancel = 1'b1;
                flash_cancel = 1'b1;
                if (i_sw.switch_closed) begin
                    press_load = 1'b1;
                    n_mode     = MODE_PRESS;
                end
            end
            MODE_PRESS: begin
                if (!i_sw.switch_closed) begin
                    n_mode = MODE_IDLE;
                end else if (press_exp) begin
                    n_relay    = 1'b1;
                    press_load = 1'b1;
                    press_val  = r_latch;
                    flash_load = 1'b1;
                    n_mode     = MODE_FLASH;
                end
            end
            MODE_FLASH: begin
                if (!i_sw.switch_closed) begin
                    n_mode = press_exp ? MODE_LATCHED : MODE_HOLD;
                end
            end
            MODE_HOLD: begin
                if (flash_exp) begin
                    n_relay    = 1'b0;
                    flash_load = 1'b1;
                    flash_val  = r_min_off;
                    n_mode     = MODE_OFF_WAIT;
                end
            end
            MODE_OFF_WAIT: begin
                if (flash_exp) begin
                    n_mode = MODE_IDLE;
                end
            end
            MODE_LATCHED: begin
                if (i_sw.switch_closed) begin
                    press_load = 1'b1;
                    n_mode     = MODE_CDEBOUNCE;
                end
            end
            MODE_CDEBOUNCE: begin
                if (!i_sw.switch_closed) begin
                    n_mode = MODE_LATCHED;
                end else if (press_exp) begin
                    n_mode = MODE_CANCELLING;
                end
            end
            MODE_CANCELLING: begin
                if (!i_sw.switch_closed) begin
                    n_mode = MODE_IDLE;
                end
            end
        endcase
        n_result.relay_on = n_relay;
        n_result.mode     = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_relay       <= 1'b0;
            r_press_cnt   <= '0;
            r_press_armed <= 1'b0;
            r_flash_cnt   <= '0;
            r_flash_armed <= 1'b0;
        end else if (in_accept) begin
            r_mode  <= n_mode;
            r_relay <= n_relay;

            if (press_load) begin
                r_press_cnt   <= TIMER_BITS'(press_val);
                r_press_armed <= 1'b1;
            end else if (press_cancel) begin
                r_press_cnt   <= '0;
                r_press_armed <= 1'b0;
            end else if (r_press_armed && r_press_cnt != '0) begin
                r_press_cnt <= r_press_cnt - TIMER_BITS'(1);
            end

            if (flash_load) begin
                r_flash_cnt   <= TIMER_BITS'(flash_val);
                r_flash_armed <= 1'b1;
            end else if (flash_cancel) begin
                r_flash_cnt   <= '0;
                r_flash_armed <= 1'b0;
            end else if (r_flash_armed && r_flash_cnt != '0) begin
                r_flash_cnt <= r_flash_cnt - TIMER_BITS'(1);
            end
        end
    end

    // Result buffer. The skid entry fills only when a beat arrives while the
    // output entry is held; input is refused until it drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (in_accept) begin
            if (!r_out_valid || out_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_pop) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (!r_out_valid || out_pop) begin
                r_out <= n_result;
            end else begin
                r_skid <= n_result;
            end
        end else if (out_pop && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.relay_on = r_out.relay_on;
    assign o_res.mode     = r_out.mode;

endmodule
